[design/cog_pkg.sv]
// Shared types and constants for the circle outline pixel generator.
// Used by cog_isqrt and circle_outline_pixel_generator; no dependencies.

package cog_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CTR_W      = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ADDR_W     = 2;

  localparam int unsigned SQ_IN_W  = 2 * COORD_BITS;
  localparam int unsigned ROOT_W   = COORD_BITS;
  localparam int unsigned SQ_CNT_W = $clog2(ROOT_W);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [CFG_W:0] SCREEN_LIM = (CFG_W + 1)'(1) << COORD_BITS;

  localparam logic [ADDR_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_COLOR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_POINT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;

endpackage

[design/cog_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on cog_pkg for operand and root widths.

module cog_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cog_pkg::SQ_IN_W-1:0]   operand_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [cog_pkg::ROOT_W-1:0]    root_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cog_pkg::SQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic [cog_pkg::SQ_IN_W-1:0]   rem_q, rem_d;
  logic [cog_pkg::SQ_IN_W-1:0]   res_q, res_d;
  logic [cog_pkg::SQ_IN_W-1:0]   bit_w;
  logic [cog_pkg::SQ_IN_W:0]     sum_w;

  assign bit_w = cog_pkg::SQ_IN_W'(1) << {cnt_q, 1'b0};
  assign sum_w = {1'b0, res_q} + {1'b0, bit_w};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cog_pkg::SQ_CNT_W'(cog_pkg::ROOT_W - 1);
      rem_d  = operand_i;
      res_d  = '0;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= sum_w) begin
        rem_d = rem_q - sum_w[cog_pkg::SQ_IN_W-1:0];
        res_d = (res_q >> 1) + bit_w;
      end else begin
        res_d = res_q >> 1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = res_q[cog_pkg::ROOT_W-1:0];

endmodule

[design/circle_outline_pixel_generator.sv]
// Top level: command sequencer, bounds check, point emission and output register.
// Depends on cog_pkg and cog_isqrt.
//
//  port group      dir  tdata (low bit up)                      tuser    tlast
//  s_axis          in   center_x[12:0] center_y[25:13]          func     -
//                       radius[37:26], zero fill
//  m_axis          out  pixel_x[11:0] pixel_y[23:12]            status   last
//                       color[55:24]
//  cfg             in   cfg_we_i, cfg_addr_i, cfg_data_i (write only)
//
// Load or idle advance: decode then status state; the status result is registered into the output register.
// Column advance: multiply plus the square root unit, then eight
// point results one per cycle while the output does not stall.
// Input is taken only while the sequencer is idle; output stalls hold emission.
// Reset clears control state and sets width 640, height 480, color 0.

module circle_outline_pixel_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cog_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // center_x, center_y, radius
  input  logic                              s_axis_tuser,  // func
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cog_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // pixel_x, pixel_y, color
  output logic [cog_pkg::STATUS_W-1:0]      m_axis_tuser,  // status
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [cog_pkg::ADDR_W-1:0]        cfg_addr_i,
  input  logic [cog_pkg::COLOR_W-1:0]       cfg_data_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SQRT   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;

  localparam int unsigned CB = cog_pkg::COORD_BITS;

  logic [2:0]                    state_q, state_d;
  logic [cog_pkg::CFG_W-1:0]     width_q, height_q;
  logic [cog_pkg::COLOR_W-1:0]   color_q;

  logic                          func_q;
  logic [cog_pkg::CTR_W-1:0]     in_cx_q, in_cy_q;
  logic [CB-1:0]                 in_r_q;

  logic [CB-1:0]                 cur_cx_q, cur_cy_q, cur_r_q, column_q;
  logic                          active_q;
  logic [2:0]                    pt_q;
  logic [cog_pkg::STATUS_W-1:0]  pend_status_q;

  logic                          out_valid_q;
  logic [CB-1:0]                 out_x_q, out_y_q;
  logic [cog_pkg::COLOR_W-1:0]   out_color_q;
  logic [cog_pkg::STATUS_W-1:0]  out_status_q;
  logic                          out_last_q;
  logic                          out_free;

  logic                          sq_start, sq_busy, sq_done;
  logic [cog_pkg::SQ_IN_W-1:0]   sq_operand;
  logic [CB-1:0]                 root;
  logic [CB-1:0]                 r_minus_i;
  logic [CB:0]                   r_plus_i;
  logic [2*CB:0]                 product;

  logic signed [CB+2:0]          cx_s, cy_s, r_s, w_s, h_s;
  logic [cog_pkg::CFG_W:0]       w_clamp, h_clamp;
  logic                          reject;
  logic                          fin;
  logic [CB-1:0]                 dx, dy, px, py;

  // square root unit
  cog_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_operand),
    .busy_o    (sq_busy),
    .done_o    (sq_done),
    .root_o    (root)
  );

  assign r_minus_i  = cur_r_q - column_q;
  assign r_plus_i   = {1'b0, cur_r_q} + {1'b0, column_q};
  assign product    = (2*CB+1)'(r_minus_i) * (2*CB+1)'(r_plus_i);
  assign sq_operand = product[cog_pkg::SQ_IN_W-1:0];

  assign w_clamp = ({1'b0, width_q} > cog_pkg::SCREEN_LIM) ? cog_pkg::SCREEN_LIM
                                                          : {1'b0, width_q};
  assign h_clamp = ({1'b0, height_q} > cog_pkg::SCREEN_LIM) ? cog_pkg::SCREEN_LIM
                                                           : {1'b0, height_q};
  assign cx_s = (CB+3)'(signed'(in_cx_q));
  assign cy_s = (CB+3)'(signed'(in_cy_q));
  assign r_s  = signed'((CB+3)'(in_r_q));
  assign w_s  = signed'((CB+3)'(w_clamp));
  assign h_s  = signed'((CB+3)'(h_clamp));
  assign reject = (cx_s - r_s < 0) || (cx_s + r_s >= w_s) ||
                  (cy_s - r_s < 0) || (cy_s + r_s >= h_s);

  assign fin = (column_q + 1'b1) == cur_r_q;
  assign dx  = pt_q[2] ? root : column_q;
  assign dy  = pt_q[2] ? column_q : root;
  assign px  = pt_q[1] ? cur_cx_q - dx : cur_cx_q + dx;
  assign py  = pt_q[0] ? cur_cy_q - dy : cur_cy_q + dy;

  assign out_free = !out_valid_q || m_axis_tready;
  assign sq_start = (state_q == S_DECODE) && (func_q != cog_pkg::FUNC_LOAD) &&
                    active_q && (column_q < cur_r_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_DECODE;
      end
      S_DECODE: state_d = sq_start ? S_SQRT : S_STATUS;
      S_SQRT: begin
        if (sq_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free && pt_q == 3'd7) state_d = S_IDLE;
      end
      S_STATUS: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      width_q       <= 13'd640;
      height_q      <= 13'd480;
      color_q       <= '0;
      cur_cx_q      <= '0;
      cur_cy_q      <= '0;
      cur_r_q       <= '0;
      column_q      <= '0;
      active_q      <= 1'b0;
      pt_q          <= '0;
      pend_status_q <= cog_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          cog_pkg::REG_WIDTH:  width_q  <= cfg_data_i[cog_pkg::CFG_W-1:0];
          cog_pkg::REG_HEIGHT: height_q <= cfg_data_i[cog_pkg::CFG_W-1:0];
          cog_pkg::REG_COLOR:  color_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_DECODE) begin
        pt_q <= '0;
        if (func_q == cog_pkg::FUNC_LOAD) begin
          if (reject) begin
            active_q      <= 1'b0;
            pend_status_q <= cog_pkg::ST_REJECT;
          end else begin
            cur_cx_q      <= in_cx_q[CB-1:0];
            cur_cy_q      <= in_cy_q[CB-1:0];
            cur_r_q       <= in_r_q;
            column_q      <= '0;
            active_q      <= (in_r_q != '0);
            pend_status_q <= cog_pkg::ST_ACCEPT;
          end
        end else if (!sq_start) begin
          active_q      <= 1'b0;
          pend_status_q <= cog_pkg::ST_IDLE;
        end
      end
      if (state_q == S_EMIT && out_free) begin
        pt_q <= pt_q + 1'b1;
        if (pt_q == 3'd7) begin
          column_q <= column_q + 1'b1;
          if (fin) active_q <= 1'b0;
        end
      end
      if ((state_q == S_EMIT || state_q == S_STATUS) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q  <= s_axis_tuser;
      in_cx_q <= s_axis_tdata[12:0];
      in_cy_q <= s_axis_tdata[25:13];
      in_r_q  <= s_axis_tdata[37:26];
    end
    if (state_q == S_EMIT && out_free) begin
      out_x_q      <= px;
      out_y_q      <= py;
      out_color_q  <= color_q;
      out_status_q <= cog_pkg::ST_POINT;
      out_last_q   <= (pt_q == 3'd7) && fin;
    end else if (state_q == S_STATUS && out_free) begin
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_color_q  <= '0;
      out_status_q <= pend_status_q;
      out_last_q   <= 1'b1;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_idle_no_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sq_busy)
    else $error("square root unit busy while sequencer idle");

  a_done_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQRT))
    else $error("square root finished outside of wait state");

  a_last_point_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && pt_q == 3'd7 && fin) |=> !active_q)
    else $error("final point emitted while circle still active");

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |=> (sq_busy && state_q == S_SQRT))
    else $error("square root did not start");

endmodule

[tb/circle_outline_pixel_generator_checker.sv]
// Scoreboard for the circle outline pixel generator: watches command, pixel and
// register-write channels, predicts every pixel/status transaction and compares.
// Depends on cog_pkg.

module circle_outline_pixel_generator_checker
  import cog_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [IN_DATA_W-1:0]    s_tdata_i,   // center_x, center_y, radius
  input  logic                    s_tuser_i,   // func
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [OUT_DATA_W-1:0]   m_tdata_i,   // pixel_x, pixel_y, color
  input  logic [STATUS_W-1:0]     m_tuser_i,   // status
  input  logic                    m_tlast_i,
  input  logic                    cfg_we_i,
  input  logic [ADDR_W-1:0]       cfg_addr_i,
  input  logic [COLOR_W-1:0]      cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    color;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } pixel_t;

  pixel_t                expected_pixels[$];
  int                    mismatches = 0;
  int                    outstanding = 0;

  logic [CFG_W-1:0]      width_q;
  logic [CFG_W-1:0]      height_q;
  logic [COLOR_W-1:0]    color_q;
  logic [COORD_BITS-1:0] ctr_x;
  logic [COORD_BITS-1:0] ctr_y;
  logic [COORD_BITS-1:0] rad;
  logic [COORD_BITS-1:0] col;
  logic                  active;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic logic [COORD_BITS-1:0] int_sqrt(input logic [SQ_IN_W-1:0] v);
    logic [COORD_BITS-1:0] root;
    logic [COORD_BITS-1:0] trial;
    root = '0;
    for (int b = COORD_BITS - 1; b >= 0; b--) begin
      trial = root | (COORD_BITS'(1) << b);
      if (SQ_IN_W'(trial) * SQ_IN_W'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void push_pixel(input logic [COORD_BITS-1:0] px,
                                     input logic [COORD_BITS-1:0] py,
                                     input logic [COLOR_W-1:0] c,
                                     input logic [STATUS_W-1:0] st, input logic fin);
    pixel_t p;
    p.x      = px;
    p.y      = py;
    p.color  = c;
    p.status = st;
    p.last   = fin;
    expected_pixels.push_back(p);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic rasterize_command(input logic func, input logic [CTR_W-1:0] cx_raw,
                                   input logic [CTR_W-1:0] cy_raw,
                                   input logic [COORD_BITS-1:0] r_raw);
    int                    cx;
    int                    cy;
    int                    r;
    int                    w;
    int                    h;
    logic [COORD_BITS-1:0] t;
    logic                  fin;
    cx = int'($signed(cx_raw));
    cy = int'($signed(cy_raw));
    r  = int'(r_raw);
    w  = (width_q > SCREEN_LIM) ? int'(SCREEN_LIM) : int'(width_q);
    h  = (height_q > SCREEN_LIM) ? int'(SCREEN_LIM) : int'(height_q);
    if (func == FUNC_LOAD) begin
      if (cx - r < 0 || cx + r >= w || cy - r < 0 || cy + r >= h) begin
        active = 1'b0;
        push_pixel('0, '0, '0, ST_REJECT, 1'b1);
      end else begin
        ctr_x  = COORD_BITS'(cx);
        ctr_y  = COORD_BITS'(cy);
        rad    = r_raw;
        col    = '0;
        active = (r > 0);
        push_pixel('0, '0, '0, ST_ACCEPT, 1'b1);
      end
    end else if (!active || col >= rad) begin
      active = 1'b0;
      push_pixel('0, '0, '0, ST_IDLE, 1'b1);
    end else begin
      t   = int_sqrt(SQ_IN_W'(rad) * SQ_IN_W'(rad) - SQ_IN_W'(col) * SQ_IN_W'(col));
      fin = (int'(col) + 1 == int'(rad));
      push_pixel(ctr_x + col, ctr_y + t, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x + col, ctr_y - t, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x - col, ctr_y + t, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x - col, ctr_y - t, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x + t, ctr_y + col, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x + t, ctr_y - col, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x - t, ctr_y + col, color_q, ST_POINT, 1'b0);
      push_pixel(ctr_x - t, ctr_y - col, color_q, ST_POINT, fin);
      col = col + 1'b1;
      if (fin) active = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      width_q  = CFG_W'(640);
      height_q = CFG_W'(480);
      color_q  = '0;
      ctr_x    = '0;
      ctr_y    = '0;
      rad      = '0;
      col      = '0;
      active   = 1'b0;
      expected_pixels.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transaction with nothing expected: status %0d", m_tuser_i);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.x, m_tdata_i[COORD_BITS-1:0]);
          check_field("pixel_y", want.y, m_tdata_i[2*COORD_BITS-1:COORD_BITS]);
          check_field("color", want.color,
                      m_tdata_i[2*COORD_BITS+COLOR_W-1:2*COORD_BITS]);
          check_field("status", want.status, m_tuser_i);
          check_field("last", want.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        rasterize_command(s_tuser_i, s_tdata_i[CTR_W-1:0], s_tdata_i[2*CTR_W-1:CTR_W],
                          s_tdata_i[2*CTR_W+COORD_BITS-1:2*CTR_W]);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_WIDTH: begin
            width_q = cfg_data_i[CFG_W-1:0];
          end
          REG_HEIGHT: begin
            height_q = cfg_data_i[CFG_W-1:0];
          end
          REG_COLOR: begin
            color_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

[tb/circle_outline_pixel_generator_tb.sv]
// Top-level testbench: clock, reset, command stimulus, receiver back-pressure and verdict.
// Depends on cog_pkg, circle_outline_pixel_generator and the pixel checker module.

module circle_outline_pixel_generator_tb;
  import cog_pkg::*;

  localparam int  IDLE_LIMIT  = 5000;
  localparam int  HOLD_CYCLES = 400;
  localparam logic FUNC_STEP  = ~FUNC_LOAD;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // center_x, center_y, radius, zero fill
  logic                  s_axis_tuser  = 1'b0; // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // pixel_x, pixel_y, color
  logic [STATUS_W-1:0]   m_axis_tuser;        // status
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [ADDR_W-1:0]     cfg_addr_i    = '0;
  logic [COLOR_W-1:0]    cfg_data_i    = '0;

  int fail_count;
  int pending;
  int sent             = 0;
  int sender_idle_pct  = 0;
  int receiver_idle_pct = 0;
  int hold_requests    = 0;
  int holds_served     = 0;
  int hold_left        = 0;
  int cur_w            = 640;
  int cur_h            = 480;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  circle_outline_pixel_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  circle_outline_pixel_generator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_command(input logic func, input logic [CTR_W-1:0] cx,
                              input logic [CTR_W-1:0] cy, input logic [COORD_BITS-1:0] r);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, r, cy, cx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic load_circle(input int cx, input int cy, input int r);
    send_command(FUNC_LOAD, CTR_W'(cx), CTR_W'(cy), COORD_BITS'(r));
  endtask

  // Centre and radius bits are ignored on a column step; randomize them anyway
  task automatic step_column();
    send_command(FUNC_STEP, CTR_W'($urandom), CTR_W'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic drain(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic program_screen(input int w, input int h, input logic [COLOR_W-1:0] c);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_WIDTH;
    cfg_data_i <= COLOR_W'(CFG_W'(w));
    @(posedge clk_i);
    cfg_addr_i <= REG_HEIGHT;
    cfg_data_i <= COLOR_W'(CFG_W'(h));
    @(posedge clk_i);
    cfg_addr_i <= REG_COLOR;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic random_sequence();
    int span_w;
    int span_h;
    int rmax;
    int r;
    int cx;
    int cy;
    int steps;
    int pick;
    span_w = (cur_w > int'(SCREEN_LIM)) ? int'(SCREEN_LIM) : cur_w;
    span_h = (cur_h > int'(SCREEN_LIM)) ? int'(SCREEN_LIM) : cur_h;
    pick   = $urandom_range(99);
    if (pick < 13) begin
      step_column();
    end else if (pick < 28 || span_w == 0 || span_h == 0) begin
      load_circle($urandom, $urandom, $urandom);
    end else begin
      rmax = ((span_w < span_h ? span_w : span_h) - 1) / 2;
      if ($urandom_range(19) == 0) r = $urandom_range(rmax, 0);
      else r = $urandom_range(rmax < 12 ? rmax : 12, 0);
      cx = $urandom_range(span_w - 1 - r, r);
      cy = $urandom_range(span_h - 1 - r, r);
      load_circle(cx, cy, r);
      steps = (r < 14) ? r : 14;
      case ($urandom_range(4))
        0: begin
          steps = $urandom_range(steps, 0);
        end
        1: begin
          if (r < 14) steps = r + 1;
        end
        default: begin
        end
      endcase
      repeat (steps) step_column();
    end
  endtask

  initial begin : stimulus
    bit hold_issued;
    int w;
    int h;
    hold_issued = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct   = 36;
    receiver_idle_pct <= 76;

    // Reset configuration: 640x480, color zero
    step_column();
    load_circle(0, 0, 0);
    step_column();
    load_circle(639, 479, 0);
    load_circle(640, 0, 0);
    load_circle(0, 480, 0);
    load_circle(-4096, 4095, 4095);
    load_circle(5, 5, 5);
    repeat (6) step_column();

    // Oversized resolution clamps to the coordinate range
    drain(30);
    program_screen(8191, 8191, 32'hFFFF_FFFF);
    load_circle(2048, 2048, 2047);
    repeat (2) step_column();
    load_circle(2048, 2048, 2048);
    step_column();
    load_circle(100, 100, 3);
    step_column();
    load_circle(4094, 4093, 1);
    step_column();

    // Zero resolution rejects everything
    drain(30);
    program_screen(0, 0, 32'h0000_0000);
    load_circle(0, 0, 0);
    step_column();

    drain(30);
    program_screen(1, 1, 32'h0F0F_F0F0);
    load_circle(0, 0, 0);

    drain(30);
    program_screen(640, 480, $urandom);
    while (sent < 150) begin
      if (!hold_issued && sent >= 80) begin
        hold_requests <= hold_requests + 1;
        hold_issued = 1'b1;
      end
      random_sequence();
    end

    sender_idle_pct   = 76;
    receiver_idle_pct <= 36;
    drain(30);
    program_screen(4096, 4096, $urandom);
    while (sent < 270) random_sequence();

    sender_idle_pct   = 0;
    receiver_idle_pct <= 0;
    drain(30);
    w = ($urandom_range(3) == 0) ? 8191 : $urandom_range(4096, 64);
    h = ($urandom_range(3) == 0) ? 8191 : $urandom_range(4096, 64);
    program_screen(w, h, $urandom);
    while (sent < 390) random_sequence();

    drain(40);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
